### rtl/core/qtom_pkg.sv
// Shared types and constants for the quadtree occupancy map core.
`default_nettype none
package qtom_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned LOGODDS_W = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OOB = 2'd1;
	localparam logic [STATUS_W-1:0] ST_POOL_FULL = 2'd2;

	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_X_LOW = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH = 2'd3;

	localparam logic signed [COORD_W-1:0] X_LOW_RST = -32'sd655360;
	localparam logic signed [COORD_W-1:0] X_HIGH_RST = 32'sd655360;
	localparam logic signed [COORD_W-1:0] Y_LOW_RST = -32'sd655360;
	localparam logic signed [COORD_W-1:0] Y_HIGH_RST = 32'sd655360;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BOUND,
		S_READ,
		S_CHECK,
		S_ALLOC,
		S_DONE
	} qtom_state_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic wr_link;
		logic wr_alloc;
		logic wr_leaf;
		logic descend;
		logic set_val;
		logic set_oob;
		logic set_full;
	} qtom_cmd_t;

	typedef struct packed {
		logic oob;
		logic child_zero;
		logic full;
		logic at_leaf;
		logic query;
	} qtom_stat_t;

endpackage
`default_nettype wire

### rtl/core/quadtree_occupancy_map_core.sv
// Top level of the quadtree occupancy map: configuration registers, sequencer, datapath.
//
//  channel   handshake                     payload
//  request   start in, busy out            req_type, pos_x, pos_y, delta
//  result    done out (one-cycle strobe)   cell_value, status
//  config    cfg_valid in, cfg_ready out   cfg_index, cfg_data
//
// An in-bounds request keeps busy high through the bounds check, a read and a check of
// each level walked, and an allocation step for each node allocated. An out-of-bounds
// point ends after the bounds check. busy drops in the idle state between requests. The
// node store (one read port, one write port, registered read) paces each level.
// Reset clears the bounds to their defaults, the allocation counter to 2 and marks the
// root node as empty; the store itself needs no clearing pass. The result cannot be
// stalled: it is valid in the cycle that done is high and holds until the next request.
`default_nettype none
module quadtree_occupancy_map_core #(
	parameter int unsigned POOL_NODES = 4096,
	parameter int unsigned MAX_LEVEL = 10,
	parameter int LOG_ODDS_MAX = 127,
	parameter int LOG_ODDS_MIN = -128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic req_type,
	input wire logic signed [qtom_pkg::COORD_W-1:0] pos_x,
	input wire logic signed [qtom_pkg::COORD_W-1:0] pos_y,
	input wire logic signed [qtom_pkg::LOGODDS_W-1:0] delta,
	output logic done,
	output logic signed [qtom_pkg::LOGODDS_W-1:0] cell_value,
	output logic [qtom_pkg::STATUS_W-1:0] status,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [qtom_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [qtom_pkg::COORD_W-1:0] cfg_data
);
	import qtom_pkg::*;

	logic signed [COORD_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;
	qtom_cmd_t cmd;
	qtom_stat_t stat;

	// configuration is always taken; it is to be written only while idle (not enforced here)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_low_q <= X_LOW_RST;
			x_high_q <= X_HIGH_RST;
			y_low_q <= Y_LOW_RST;
			y_high_q <= Y_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_LOW: x_low_q <= cfg_data;
				REG_X_HIGH: x_high_q <= cfg_data;
				REG_Y_LOW: y_low_q <= cfg_data;
				REG_Y_HIGH: y_high_q <= cfg_data;
				default: x_low_q <= x_low_q;
			endcase
		end
	end

	// sequence the walk: bounds check, then one read per level
	qtom_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.stat(stat),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	// hold the node store, the box being narrowed and the result
	qtom_dpath #(
		.POOL_NODES(POOL_NODES),
		.MAX_LEVEL(MAX_LEVEL),
		.LOG_ODDS_MAX(LOG_ODDS_MAX),
		.LOG_ODDS_MIN(LOG_ODDS_MIN)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req_type(req_type),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.delta(delta),
		.x_low(x_low_q),
		.x_high(x_high_q),
		.y_low(y_low_q),
		.y_high(y_high_q),
		.stat(stat),
		.cell_value(cell_value),
		.status(status)
	);

endmodule
`default_nettype wire

### rtl/core/qtom_ctrl.sv
// Walk sequencer for the quadtree occupancy map core.
`default_nettype none
module qtom_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire qtom_pkg::qtom_stat_t stat,
	output qtom_pkg::qtom_cmd_t cmd,
	output logic busy,
	output logic done
);
	import qtom_pkg::*;

	qtom_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_BOUND;
			end
			S_BOUND: begin
				state_d = stat.oob ? S_DONE : S_READ;
			end
			S_READ: state_d = S_CHECK;
			S_CHECK: begin
				priority if (stat.at_leaf) state_d = S_DONE;
				else if (!stat.child_zero) state_d = S_READ;
				else if (stat.query || stat.full) state_d = S_DONE;
				else state_d = S_ALLOC;
			end
			S_ALLOC: state_d = S_READ;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = start;
			S_BOUND: cmd.set_oob = stat.oob;
			S_READ: cmd.rd = 1'b1;
			S_CHECK: begin
				priority if (stat.at_leaf) begin
					cmd.set_val = stat.query;
					cmd.wr_leaf = !stat.query;
				end else if (!stat.child_zero) begin
					cmd.descend = 1'b1;
				end else if (stat.query) begin
					cmd.set_val = 1'b0;
				end else if (stat.full) begin
					cmd.set_full = 1'b1;
				end else begin
					cmd.wr_link = 1'b1;
				end
			end
			S_ALLOC: begin
				cmd.wr_alloc = 1'b1;
				cmd.descend = 1'b1;
			end
			S_DONE: cmd = '0;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

### rtl/core/qtom_dpath.sv
// Node store, box bounds, walk registers and result registers.
`default_nettype none
module qtom_dpath #(
	parameter int unsigned POOL_NODES = 4096,
	parameter int unsigned MAX_LEVEL = 10,
	parameter int LOG_ODDS_MAX = 127,
	parameter int LOG_ODDS_MIN = -128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire qtom_pkg::qtom_cmd_t cmd,
	input wire logic req_type,
	input wire logic signed [qtom_pkg::COORD_W-1:0] pos_x,
	input wire logic signed [qtom_pkg::COORD_W-1:0] pos_y,
	input wire logic signed [qtom_pkg::LOGODDS_W-1:0] delta,
	input wire logic signed [qtom_pkg::COORD_W-1:0] x_low,
	input wire logic signed [qtom_pkg::COORD_W-1:0] x_high,
	input wire logic signed [qtom_pkg::COORD_W-1:0] y_low,
	input wire logic signed [qtom_pkg::COORD_W-1:0] y_high,
	output qtom_pkg::qtom_stat_t stat,
	output logic signed [qtom_pkg::LOGODDS_W-1:0] cell_value,
	output logic [qtom_pkg::STATUS_W-1:0] status
);
	import qtom_pkg::*;

	localparam int unsigned IDX_W = $clog2(POOL_NODES);
	localparam int unsigned CNT_W = $clog2(POOL_NODES + 1);
	localparam int unsigned LVL_W = $clog2(MAX_LEVEL + 1);
	localparam int unsigned WORD_W = 4 * IDX_W + LOGODDS_W;
	localparam int unsigned VAL_LSB = 4 * IDX_W;

	logic [WORD_W-1:0] mem [POOL_NODES];
	logic [WORD_W-1:0] rd_data_q;
	logic rd_root_q;
	logic root_valid_q;
	logic [CNT_W-1:0] next_free_q;

	logic query_q;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [LOGODDS_W-1:0] delta_q;
	logic signed [COORD_W-1:0] xl_q, xh_q, yl_q, yh_q;
	logic [IDX_W-1:0] node_q, child_q;
	logic [LVL_W-1:0] level_q;
	logic signed [LOGODDS_W-1:0] val_q;
	logic [STATUS_W-1:0] status_q;

	logic [WORD_W-1:0] word;
	logic signed [COORD_W:0] sum_x, sum_y;
	logic signed [COORD_W-1:0] mid_x, mid_y;
	logic east, north;
	logic [1:0] quad;
	logic [IDX_W-1:0] child;
	logic signed [LOGODDS_W-1:0] leaf_val;
	logic signed [LOGODDS_W:0] leaf_sum, leaf_new;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [WORD_W-1:0] wr_data;

	// the root entry reads as cleared until a child link is first written to it
	assign word = rd_root_q ? '0 : rd_data_q;

	assign sum_x = (COORD_W+1)'(xl_q) + (COORD_W+1)'(xh_q);
	assign sum_y = (COORD_W+1)'(yl_q) + (COORD_W+1)'(yh_q);
	assign mid_x = COORD_W'(sum_x >>> 1);
	assign mid_y = COORD_W'(sum_y >>> 1);
	assign east = (px_q >= mid_x);
	assign north = (py_q >= mid_y);
	assign quad = north ? (east ? 2'd1 : 2'd0) : (east ? 2'd3 : 2'd2);
	assign child = word[quad * IDX_W +: IDX_W];

	assign leaf_val = word[VAL_LSB +: LOGODDS_W];
	assign leaf_sum = (LOGODDS_W+1)'(leaf_val) + (LOGODDS_W+1)'(delta_q);

	always_comb begin
		priority if (leaf_sum > (LOGODDS_W+1)'(LOG_ODDS_MAX))
			leaf_new = (LOGODDS_W+1)'(LOG_ODDS_MAX);
		else if (leaf_sum < (LOGODDS_W+1)'(LOG_ODDS_MIN))
			leaf_new = (LOGODDS_W+1)'(LOG_ODDS_MIN);
		else
			leaf_new = leaf_sum;
	end

	assign stat.oob = (px_q < xl_q) || (px_q >= xh_q) || (py_q < yl_q) || (py_q >= yh_q);
	assign stat.child_zero = (child == '0);
	assign stat.full = (next_free_q >= CNT_W'(POOL_NODES));
	assign stat.at_leaf = (level_q == LVL_W'(MAX_LEVEL));
	assign stat.query = query_q;

	always_comb begin
		wr_en = cmd.wr_link || cmd.wr_alloc || cmd.wr_leaf;
		wr_addr = node_q;
		wr_data = word;
		priority if (cmd.wr_alloc) begin
			wr_addr = child_q;
			wr_data = '0;
		end else if (cmd.wr_link) begin
			wr_data[quad * IDX_W +: IDX_W] = next_free_q[IDX_W-1:0];
		end else begin
			wr_data[VAL_LSB +: LOGODDS_W] = leaf_new[LOGODDS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd) rd_data_q <= mem[node_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_valid_q <= 1'b0;
			next_free_q <= CNT_W'(2);
			rd_root_q <= 1'b1;
		end else begin
			if (cmd.rd) rd_root_q <= (node_q == IDX_W'(1)) && !root_valid_q;
			if (cmd.wr_link) begin
				next_free_q <= next_free_q + CNT_W'(1);
				if (node_q == IDX_W'(1)) root_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			query_q <= req_type;
			px_q <= pos_x;
			py_q <= pos_y;
			delta_q <= delta;
			xl_q <= x_low;
			xh_q <= x_high;
			yl_q <= y_low;
			yh_q <= y_high;
			node_q <= IDX_W'(1);
			level_q <= LVL_W'(1);
			val_q <= '0;
			status_q <= ST_DONE;
		end
		if (cmd.wr_link) child_q <= next_free_q[IDX_W-1:0];
		if (cmd.descend) begin
			if (east) xl_q <= mid_x; else xh_q <= mid_x;
			if (north) yl_q <= mid_y; else yh_q <= mid_y;
			node_q <= cmd.wr_alloc ? child_q : child;
			level_q <= level_q + LVL_W'(1);
		end
		if (cmd.set_val) val_q <= leaf_val;
		if (cmd.set_oob) status_q <= ST_OOB;
		if (cmd.set_full) status_q <= ST_POOL_FULL;
	end

	assign cell_value = val_q;
	assign status = status_q;

endmodule
`default_nettype wire

### rtl/core/qtom_checker.sv
// Port-level checks for the quadtree occupancy map core, with its bind.
`default_nettype none
module qtom_port_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic [1:0] status,
	input wire logic [7:0] cell_value
);
	import qtom_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result shown while idle");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("request accepted but no walk started");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_DONE || status == ST_OOB || status == ST_POOL_FULL))
		else $error("undefined status code");
	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_DONE) |-> (cell_value == 8'd0))
		else $error("non-zero value on a failed request");

endmodule

bind quadtree_occupancy_map_core qtom_port_checker u_qtom_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.status(status),
	.cell_value(cell_value)
);
`default_nettype wire
